// File: rtl/core/rtmu_pkg.sv
// ----------------------------------------------------------------------------
// rtmu_pkg: range table match and union package
// Shared codes, defaults and controller/datapath interface structs.
// ----------------------------------------------------------------------------
package rtmu_pkg;

    localparam int MAX_RANGES_DEF = 256;
    localparam int VALUE_BITS_DEF = 50;
    localparam int HIT_W          = 32;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_QUERY = 2'd1,
        CMD_TOTAL = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd_e;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_REV  = 2'd2
    } t_status_e;

    typedef struct packed {
        logic load;
        logic ins_init;
        logic ins_read;
        logic ins_shift;
        logic ins_place;
        logic walk_init;
        logic walk_step;
        logic clear;
        logic res_load;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd_e cmd;
        logic   add_drop;
        logic   idx_zero;
        logic   prev_greater;
        logic   walk_done;
    } t_dp_sts;

endpackage

// File: rtl/core/rtmu_dp.sv
// ----------------------------------------------------------------------------
// rtmu_dp: range table datapath
// Sorted range memory, insertion shift, table walk, hit counter, result beat.
// ----------------------------------------------------------------------------
module rtmu_dp #(
    parameter int MAX_RANGES = rtmu_pkg::MAX_RANGES_DEF,
    parameter int VALUE_BITS = rtmu_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rtmu_pkg::t_dp_cmd             i_cmd_bus,
    output rtmu_pkg::t_dp_sts             o_sts_bus,
    input  logic [1:0]                    i_cmd,
    input  logic [VALUE_BITS-1:0]         i_range_start,
    input  logic [VALUE_BITS-1:0]         i_range_end,
    input  logic [VALUE_BITS-1:0]         i_probe_value,
    output logic                          o_is_member,
    output logic [rtmu_pkg::HIT_W-1:0]    o_hit_total,
    output logic [VALUE_BITS:0]           o_covered_count,
    output logic [1:0]                    o_status
);

    localparam int AW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
    localparam int CW = $clog2(MAX_RANGES + 1);
    localparam int EW = 2 * VALUE_BITS;

    logic [EW-1:0]               r_mem [MAX_RANGES];
    logic [EW-1:0]               r_rdata;
    logic [AW-1:0]               raddr;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [EW-1:0]               wdata;

    rtmu_pkg::t_cmd_e            r_cmd;
    rtmu_pkg::t_status_e         r_status;
    logic [VALUE_BITS-1:0]       r_lo;
    logic [VALUE_BITS-1:0]       r_hi;
    logic [VALUE_BITS-1:0]       r_probe;
    logic [CW-1:0]               r_count;
    logic [CW-1:0]               r_idx;
    logic                        r_rd_vld;
    logic                        r_member;
    logic                        r_first;
    logic [VALUE_BITS-1:0]       r_cur_lo;
    logic [VALUE_BITS-1:0]       r_cur_hi;
    logic [VALUE_BITS:0]         r_total;
    logic [rtmu_pkg::HIT_W-1:0]  r_hit;
    logic [rtmu_pkg::HIT_W-1:0]  n_hit;

    logic [VALUE_BITS-1:0]       rd_lo;
    logic [VALUE_BITS-1:0]       rd_hi;
    logic [VALUE_BITS:0]         seg_len;
    logic                        joins;
    logic                        full_now;

    assign rd_lo    = r_rdata[EW-1:VALUE_BITS];
    assign rd_hi    = r_rdata[VALUE_BITS-1:0];
    assign seg_len  = {1'b0, r_cur_hi} - {1'b0, r_cur_lo} + {{VALUE_BITS{1'b0}}, 1'b1};
    assign joins    = {1'b0, rd_lo} <= ({1'b0, r_cur_hi} + {{VALUE_BITS{1'b0}}, 1'b1});
    assign full_now = r_count == CW'(MAX_RANGES);

    assign raddr = i_cmd_bus.ins_read ? AW'(r_idx - CW'(1)) : r_idx[AW-1:0];
    assign we    = i_cmd_bus.ins_shift || i_cmd_bus.ins_place;
    assign waddr = r_idx[AW-1:0];
    assign wdata = i_cmd_bus.ins_shift ? r_rdata : {r_lo, r_hi};

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rdata <= r_mem[raddr];
    end

    always_comb begin
        n_hit = r_hit;
        if (r_cmd == rtmu_pkg::CMD_QUERY && r_member && r_hit != '1) begin
            n_hit = r_hit + rtmu_pkg::HIT_W'(1);
        end
    end

    assign o_sts_bus.cmd          = r_cmd;
    assign o_sts_bus.add_drop     = r_status != rtmu_pkg::ST_OK;
    assign o_sts_bus.idx_zero     = r_idx == '0;
    assign o_sts_bus.prev_greater = rd_lo > r_lo;
    assign o_sts_bus.walk_done    = (r_idx == r_count) && !r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_hit    <= '0;
            r_rd_vld <= 1'b0;
            r_cmd    <= rtmu_pkg::CMD_ADD;
            r_status <= rtmu_pkg::ST_OK;
        end else begin
            if (i_cmd_bus.load) begin
                r_cmd   <= rtmu_pkg::t_cmd_e'(i_cmd);
                r_lo    <= i_range_start;
                r_hi    <= i_range_end;
                r_probe <= i_probe_value;
                if (i_cmd != rtmu_pkg::CMD_ADD) begin
                    r_status <= rtmu_pkg::ST_OK;
                end else if (i_range_start > i_range_end) begin
                    r_status <= rtmu_pkg::ST_REV;
                end else if (full_now) begin
                    r_status <= rtmu_pkg::ST_FULL;
                end else begin
                    r_status <= rtmu_pkg::ST_OK;
                end
            end
            if (i_cmd_bus.ins_init) begin
                r_idx <= r_count;
            end
            if (i_cmd_bus.ins_shift) begin
                r_idx <= r_idx - CW'(1);
            end
            if (i_cmd_bus.ins_place) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd_bus.walk_init) begin
                r_idx    <= '0;
                r_rd_vld <= 1'b0;
                r_member <= 1'b0;
                r_first  <= 1'b1;
                r_total  <= '0;
            end
            if (i_cmd_bus.walk_step) begin
                if (r_idx != r_count) begin
                    r_idx    <= r_idx + CW'(1);
                    r_rd_vld <= 1'b1;
                end else begin
                    r_rd_vld <= 1'b0;
                end
                if (r_rd_vld) begin
                    if (r_probe >= rd_lo && r_probe <= rd_hi) begin
                        r_member <= 1'b1;
                    end
                    if (r_first) begin
                        r_first  <= 1'b0;
                        r_cur_lo <= rd_lo;
                        r_cur_hi <= rd_hi;
                    end else if (joins) begin
                        if (rd_hi > r_cur_hi) begin
                            r_cur_hi <= rd_hi;
                        end
                    end else begin
                        r_total  <= r_total + seg_len;
                        r_cur_lo <= rd_lo;
                        r_cur_hi <= rd_hi;
                    end
                end
            end
            if (i_cmd_bus.clear) begin
                r_count <= '0;
                r_hit   <= '0;
            end
            if (i_cmd_bus.res_load) begin
                r_hit <= n_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.res_load) begin
            o_is_member     <= (r_cmd == rtmu_pkg::CMD_QUERY) && r_member;
            o_hit_total     <= n_hit;
            o_status        <= r_status;
            if (r_cmd == rtmu_pkg::CMD_TOTAL && !r_first) begin
                o_covered_count <= r_total + seg_len;
            end else begin
                o_covered_count <= '0;
            end
        end
    end

endmodule

// File: rtl/core/rtmu_ctl.sv
// ----------------------------------------------------------------------------
// rtmu_ctl: range table controller
// Sequences add, query, total and clear items and owns both handshakes.
// ----------------------------------------------------------------------------
module rtmu_ctl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output rtmu_pkg::t_dp_cmd o_cmd_bus,
    input  rtmu_pkg::t_dp_sts i_sts_bus
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_CHK,
        S_INS_CMP,
        S_WALK,
        S_DONE
    } t_state_e;

    t_state_e r_state;
    t_state_e n_state;
    logic     r_out_vld;
    logic     n_out_vld;

    always_comb begin
        o_cmd_bus = '0;
        n_state   = r_state;
        n_out_vld = r_out_vld && i_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd_bus.load = 1'b1;
                    n_state        = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts_bus.cmd) inside
                    rtmu_pkg::CMD_ADD: begin
                        if (i_sts_bus.add_drop) begin
                            n_state = S_DONE;
                        end else begin
                            o_cmd_bus.ins_init = 1'b1;
                            n_state            = S_INS_CHK;
                        end
                    end
                    rtmu_pkg::CMD_QUERY, rtmu_pkg::CMD_TOTAL: begin
                        o_cmd_bus.walk_init = 1'b1;
                        n_state             = S_WALK;
                    end
                    default: begin
                        o_cmd_bus.clear = 1'b1;
                        n_state         = S_DONE;
                    end
                endcase
            end
            S_INS_CHK: begin
                if (i_sts_bus.idx_zero) begin
                    o_cmd_bus.ins_place = 1'b1;
                    n_state             = S_DONE;
                end else begin
                    o_cmd_bus.ins_read = 1'b1;
                    n_state            = S_INS_CMP;
                end
            end
            S_INS_CMP: begin
                if (i_sts_bus.prev_greater) begin
                    o_cmd_bus.ins_shift = 1'b1;
                    n_state             = S_INS_CHK;
                end else begin
                    o_cmd_bus.ins_place = 1'b1;
                    n_state             = S_DONE;
                end
            end
            S_WALK: begin
                if (i_sts_bus.walk_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd_bus.walk_step = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_vld || !i_stall) begin
                    o_cmd_bus.res_load = 1'b1;
                    n_out_vld          = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_stall = r_state != S_IDLE;
    assign o_valid = r_out_vld;

endmodule

// File: rtl/core/range_table_match_and_union.sv
// ----------------------------------------------------------------------------
// range_table_match_and_union: range table with membership and union length
// Stores inclusive ranges kept sorted by start; answers queries and totals.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_stall carries one item per beat: i_cmd selects
//   add, query, total or clear. Output channel o_valid/i_stall carries one
//   result beat per item.
//   An add shifts each stored entry with a larger start up one slot in the
//   range memory, then writes the new range into the freed slot. Query and
//   total walk the stored entries one per cycle. Clear and dropped adds go
//   straight to the result.
//   One item is in flight at a time; the next is taken as soon as its
//   result sits in the output register, even while that beat is stalled.
//   A stalled result holds; an item that finishes while the register is
//   still full waits in the controller and the input stays stalled.
//   Synchronous reset empties the table and zeroes the hit counter.
// ----------------------------------------------------------------------------
module range_table_match_and_union #(
    parameter int MAX_RANGES = rtmu_pkg::MAX_RANGES_DEF,
    parameter int VALUE_BITS = rtmu_pkg::VALUE_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_cmd,
    input  logic [VALUE_BITS-1:0]         i_range_start,
    input  logic [VALUE_BITS-1:0]         i_range_end,
    input  logic [VALUE_BITS-1:0]         i_probe_value,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_is_member,
    output logic [rtmu_pkg::HIT_W-1:0]    o_hit_total,
    output logic [VALUE_BITS:0]           o_covered_count,
    output logic [1:0]                    o_status
);

    rtmu_pkg::t_dp_cmd cmd_bus;
    rtmu_pkg::t_dp_sts sts_bus;

    rtmu_ctl u_ctl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_cmd_bus (cmd_bus),
        .i_sts_bus (sts_bus)
    );

    rtmu_dp #(
        .MAX_RANGES (MAX_RANGES),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_bus       (cmd_bus),
        .o_sts_bus       (sts_bus),
        .i_cmd           (i_cmd),
        .i_range_start   (i_range_start),
        .i_range_end     (i_range_end),
        .i_probe_value   (i_probe_value),
        .o_is_member     (o_is_member),
        .o_hit_total     (o_hit_total),
        .o_covered_count (o_covered_count),
        .o_status        (o_status)
    );

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after accepted beat");

    a_member_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_member |-> o_hit_total != '0)
        else $error("member result with zero hit total");

    a_drop_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != rtmu_pkg::ST_OK |-> !o_is_member && o_covered_count == '0)
        else $error("dropped add carries query or total data");
`endif

endmodule
